[rtl/core/rgbbmp_pkg.sv]
// Shared types, constants and helper functions for the RGB565 to 24-bit BMP writer.
// Used by every module under rtl/core; depends on nothing.
package rgbbmp_pkg;

	// Field and register widths
	localparam int DIM_W     = 11;
	localparam int STRIDE_W  = 13;
	localparam int SIZE_W    = 24;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Register reset values and default size limits
	localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd320;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd240;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	// BMP header layout
	localparam logic [31:0] HDR_BYTES      = 32'd54;
	localparam logic [31:0] INFO_HDR_BYTES = 32'd40;
	localparam logic [31:0] PIXELS_PER_M   = 32'd2835;
	localparam logic [15:0] PLANES         = 16'd1;
	localparam logic [15:0] BITS_PER_PIXEL = 16'd24;
	localparam logic [7:0]  HDR_MAGIC_B    = 8'h42;
	localparam logic [7:0]  HDR_MAGIC_M    = 8'h4D;
	localparam logic [5:0]  HDR_LAST_IDX   = 6'd53;

	// One classified pixel, as handed from front to back
	typedef struct packed {
		logic                hdr;
		logic                eoi;
		logic [1:0]          pad;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [STRIDE_W-1:0] stride;
		logic [7:0]          blue;
		logic [7:0]          green;
		logic [7:0]          red;
	} cmd_t;

	// Expand a 5-bit channel to v*255/31: 8v plus floor(7v/31)
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [7:0] v7;
		logic [7:0] frac;
		v7   = {v, 3'b000} - {3'b000, v};
		frac = '0;
		for (int k = 1; k <= 7; k++) begin
			if (v7 >= 8'(31 * k))
				frac = frac + 8'd1;
		end
		return {v, 3'b000} + frac;
	endfunction

	// Expand a 6-bit channel to v*255/63: 4v plus floor(v/21)
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [7:0] frac;
		if (v >= 6'd63)
			frac = 8'd3;
		else if (v >= 6'd42)
			frac = 8'd2;
		else if (v >= 6'd21)
			frac = 8'd1;
		else
			frac = 8'd0;
		return {v, 2'b00} + frac;
	endfunction

	// Byte idx of the 54-byte little-endian file and info header
	function automatic logic [7:0] hdr_byte(
		input logic [5:0]        idx,
		input logic [DIM_W-1:0]  w,
		input logic [DIM_W-1:0]  h,
		input logic [SIZE_W-1:0] dsize
	);
		logic [31:0] fsize;
		logic [31:0] w32;
		logic [31:0] h32;
		logic [31:0] d32;
		logic [7:0]  b;
		fsize = 32'(dsize) + HDR_BYTES;
		w32   = 32'(w);
		h32   = 32'(h);
		d32   = 32'(dsize);
		case (idx)
			6'd0:  b = HDR_MAGIC_B;
			6'd1:  b = HDR_MAGIC_M;
			6'd2:  b = fsize[7:0];
			6'd3:  b = fsize[15:8];
			6'd4:  b = fsize[23:16];
			6'd5:  b = fsize[31:24];
			6'd10: b = HDR_BYTES[7:0];
			6'd11: b = HDR_BYTES[15:8];
			6'd12: b = HDR_BYTES[23:16];
			6'd13: b = HDR_BYTES[31:24];
			6'd14: b = INFO_HDR_BYTES[7:0];
			6'd15: b = INFO_HDR_BYTES[15:8];
			6'd16: b = INFO_HDR_BYTES[23:16];
			6'd17: b = INFO_HDR_BYTES[31:24];
			6'd18: b = w32[7:0];
			6'd19: b = w32[15:8];
			6'd20: b = w32[23:16];
			6'd21: b = w32[31:24];
			6'd22: b = h32[7:0];
			6'd23: b = h32[15:8];
			6'd24: b = h32[23:16];
			6'd25: b = h32[31:24];
			6'd26: b = PLANES[7:0];
			6'd27: b = PLANES[15:8];
			6'd28: b = BITS_PER_PIXEL[7:0];
			6'd29: b = BITS_PER_PIXEL[15:8];
			6'd34: b = d32[7:0];
			6'd35: b = d32[15:8];
			6'd36: b = d32[23:16];
			6'd37: b = d32[31:24];
			6'd38: b = PIXELS_PER_M[7:0];
			6'd39: b = PIXELS_PER_M[15:8];
			6'd40: b = PIXELS_PER_M[23:16];
			6'd41: b = PIXELS_PER_M[31:24];
			6'd42: b = PIXELS_PER_M[7:0];
			6'd43: b = PIXELS_PER_M[15:8];
			6'd44: b = PIXELS_PER_M[23:16];
			6'd45: b = PIXELS_PER_M[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/core/rgbbmp_front.sv]
// Front end: clamps the image size, tracks column, row and header state,
// expands the pixel and builds one queue command per pixel. Uses rgbbmp_pkg.
module rgbbmp_front #(
	parameter int MAX_WIDTH  = rgbbmp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rgbbmp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rgbbmp_pkg::DIM_W-1:0]  image_width,
	input  logic [rgbbmp_pkg::DIM_W-1:0]  image_height,
	input  logic                          accept,
	input  logic [15:0]                   pixel_rgb565,
	output rgbbmp_pkg::cmd_t              cmd
);
	import rgbbmp_pkg::*;

	logic [DIM_W-1:0]    w_eff;
	logic [DIM_W-1:0]    h_eff;
	logic [DIM_W-1:0]    col_q;
	logic [DIM_W-1:0]    row_q;
	logic                hdr_done_q;
	logic [DIM_W:0]      col_inc;
	logic [DIM_W:0]      row_inc;
	logic                row_end;
	logic                img_end;
	logic [STRIDE_W-1:0] triple;
	logic [STRIDE_W-1:0] stride_raw;
	logic [1:0]          pad_bytes;

	// Clamp the size registers to 1..MAX
	always_comb begin
		if (image_width == '0)
			w_eff = DIM_W'(1);
		else if (32'(image_width) > 32'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = image_width;
		if (image_height == '0)
			h_eff = DIM_W'(1);
		else if (32'(image_height) > 32'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = image_height;
	end

	// Row stride rounded up to four bytes, and the padding that gets there
	assign triple     = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
	assign stride_raw = triple + STRIDE_W'(3);
	assign pad_bytes  = 2'b00 - triple[1:0];

	// Detect end of row and end of image
	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign row_end = col_inc >= {1'b0, w_eff};
	assign img_end = row_end && (row_inc >= {1'b0, h_eff});

	// Advance position and header state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			hdr_done_q <= 1'b0;
		end else if (accept) begin
			hdr_done_q <= !img_end;
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_inc[DIM_W-1:0];
			end else begin
				col_q <= col_inc[DIM_W-1:0];
			end
		end
	end

	// Build the command for the back end
	always_comb begin
		cmd.hdr    = !hdr_done_q;
		cmd.eoi    = img_end;
		cmd.pad    = row_end ? pad_bytes : 2'b00;
		cmd.width  = w_eff;
		cmd.height = h_eff;
		cmd.stride = {stride_raw[STRIDE_W-1:2], 2'b00};
		cmd.blue   = expand5(pixel_rgb565[4:0]);
		cmd.green  = expand6(pixel_rgb565[10:5]);
		cmd.red    = expand5(pixel_rgb565[15:11]);
	end

endmodule

[rtl/core/rgbbmp_queue.sv]
// Short command queue between the front and back ends.
// Holds cmd_t entries from rgbbmp_pkg; first in, first out.
module rgbbmp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rgbbmp_pkg::cmd_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output rgbbmp_pkg::cmd_t rd_data
);
	import rgbbmp_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	cmd_t             entry_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(Q_DEPTH);
	assign valid   = count_q != '0;
	assign rd_data = entry_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/core/rgbbmp_back.sv]
// Back end: walks one command at a time through header, pixel and padding
// bytes into a one-entry output register. Uses rgbbmp_pkg.
module rgbbmp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  rgbbmp_pkg::cmd_t q_data,
	output logic             pop,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data_byte,
	output logic             last_of_run,
	output logic             end_of_image
);
	import rgbbmp_pkg::*;

	localparam logic [1:0] ST_HDR = 2'd0;
	localparam logic [1:0] ST_PIX = 2'd1;
	localparam logic [1:0] ST_PAD = 2'd2;

	logic              busy_q;
	logic [1:0]        state_q;
	logic [5:0]        idx_q;
	cmd_t              cmd_q;
	logic [SIZE_W-1:0] dsize_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              eoi_q;

	logic              take;
	logic              advance;
	logic              final_byte;
	logic [7:0]        next_byte;
	logic [1:0]        state_nxt;
	logic [5:0]        idx_nxt;

	assign take    = !out_valid_q || out_ready;
	assign advance = busy_q && take;

	// Select the current byte and the step after it
	always_comb begin
		next_byte  = 8'h00;
		final_byte = 1'b0;
		state_nxt  = state_q;
		idx_nxt    = idx_q + 1'b1;
		unique case (state_q)
			ST_HDR: begin
				next_byte = hdr_byte(idx_q, cmd_q.width, cmd_q.height, dsize_q);
				if (idx_q == HDR_LAST_IDX) begin
					state_nxt = ST_PIX;
					idx_nxt   = '0;
				end
			end
			ST_PIX: begin
				case (idx_q[1:0])
					2'd0:    next_byte = cmd_q.blue;
					2'd1:    next_byte = cmd_q.green;
					default: next_byte = cmd_q.red;
				endcase
				if (idx_q[1:0] == 2'd2) begin
					final_byte = cmd_q.pad == 2'b00;
					state_nxt  = ST_PAD;
					idx_nxt    = '0;
				end
			end
			ST_PAD: begin
				next_byte  = 8'h00;
				final_byte = idx_q[1:0] == (cmd_q.pad - 2'd1);
			end
			default: begin
				final_byte = 1'b1;
			end
		endcase
	end

	// Take the next command when idle or as the current one finishes
	assign pop = q_valid && (!busy_q || (advance && final_byte));

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			state_q     <= ST_HDR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= 1'b1;
				state_q <= q_data.hdr ? ST_HDR : ST_PIX;
				idx_q   <= '0;
			end else if (advance) begin
				if (final_byte) begin
					busy_q <= 1'b0;
				end else begin
					state_q <= state_nxt;
					idx_q   <= idx_nxt;
				end
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Latch the command and its data size; load the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= q_data;
			dsize_q <= SIZE_W'(q_data.stride) * SIZE_W'(q_data.height);
		end
		if (advance) begin
			byte_q <= next_byte;
			last_q <= final_byte;
			eoi_q  <= final_byte && cmd_q.eoi;
		end
	end

	assign busy         = busy_q;
	assign out_valid    = out_valid_q;
	assign data_byte    = byte_q;
	assign last_of_run  = last_q;
	assign end_of_image = eoi_q;

endmodule

[rtl/core/rgb565_to_bmp24_stream_writer.sv]
// RGB565 pixel stream to 24-bit BMP byte stream: top level.
// Instantiates rgbbmp_front, rgbbmp_queue and rgbbmp_back; uses rgbbmp_pkg.
//
// Feed pixels bottom row first, left to right. Each pixel becomes blue, green and red
// bytes on the byte-wide output, preceded by the 54-byte header on the first pixel of an
// image and followed by zero padding to a four-byte row boundary on the last pixel of a
// row. The output port moves one byte per cycle unless out_ready stalls it, and the next
// command is popped as the final byte of the current one is taken. Input is accepted
// whenever the two-entry command queue has room, so up to two pixels can wait behind the
// one being emitted. The first byte passes through the queue, the back end's command
// register and the output register. last_of_run marks the final byte of each pixel,
// end_of_image the final byte of the file. Width and height (index 0 and 1 on the
// configuration port, clamped to 1..MAX) should only be written while no output is
// pending.
module rgb565_to_bmp24_stream_writer #(
	parameter int MAX_WIDTH  = rgbbmp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rgbbmp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rgbbmp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbbmp_pkg::DIM_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [15:0]                       pixel_rgb565,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        data_byte,
	output logic                              last_of_run,
	output logic                              end_of_image
);
	import rgbbmp_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             accept;
	cmd_t             front_cmd;
	cmd_t             q_data;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	logic             back_busy;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a pixel whenever the queue has room
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	rgbbmp_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.accept       (accept),
		.pixel_rgb565 (pixel_rgb565),
		.cmd          (front_cmd)
	);

	rgbbmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.rd_data   (q_data)
	);

	rgbbmp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (q_pop),
		.busy         (back_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.last_of_run  (last_of_run),
		.end_of_image (end_of_image)
	);

	// The file's final byte also closes its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_image |-> last_of_run)
		else $error("end_of_image without last_of_run");

	// A new file starts with the magic byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && end_of_image |=> !out_valid || data_byte == HDR_MAGIC_B)
		else $error("file does not open with header magic");

	// A full queue only happens while the back end is working
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> back_busy)
		else $error("input stalled with idle back end");

	// A popped command always starts the back end
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> back_busy)
		else $error("back end idle after pop");

endmodule

[bench/bmp_stream_checker.sv]
`timescale 1ns / 1ps
// Checker for the RGB565 to 24-bit BMP writer: watches the register, pixel and byte channels,
// predicts every file byte from the accepted pixels and compares it with the output.
// Depends on rgbbmp_pkg for port widths and register indexes.
module bmp_stream_checker #(
	parameter int MAX_W = rgbbmp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_H = rgbbmp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [rgbbmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbbmp_pkg::DIM_W-1:0]     cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [15:0]                      pixel_rgb565,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             last_of_run,
	input  logic                             end_of_image,
	output int                               mismatches,
	output int                               outstanding,
	output int                               bytes_seen,
	output int                               files_done
);
	import rgbbmp_pkg::*;

	// BMP header constants, kept apart from the design's own copies
	localparam logic [7:0]  MAGIC_B        = 8'h42;
	localparam logic [7:0]  MAGIC_M        = 8'h4D;
	localparam logic [31:0] HEADER_LEN     = 32'd54;
	localparam logic [31:0] INFO_LEN       = 32'd40;
	localparam logic [31:0] PELS_PER_METER = 32'd2835;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eoi;
	} file_byte_t;

	file_byte_t       expected_file_bytes[$];
	file_byte_t       got_byte;
	file_byte_t       want_byte;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	int unsigned      col_pos;
	int unsigned      row_pos;
	bit               header_sent;
	int               err_cnt;
	int               byte_cnt;
	int               file_cnt;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
		if (v == '0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return 32'(v);
	endfunction

	function automatic int unsigned row_stride(input int unsigned w);
		return (w * 3 + 3) & ~32'd3;
	endfunction

	// Scale a channel to 8 bits as v*255/full, truncated
	function automatic logic [7:0] scale_chan(input int unsigned v, input int unsigned full);
		return 8'(v * 255 / full);
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		expected_file_bytes.push_back('{data: b, last: 1'b0, eoi: 1'b0});
	endtask

	// Little-endian field of n bytes
	task automatic queue_le(input logic [31:0] v, input int n);
		for (int k = 0; k < n; k++)
			queue_byte(v[8*k +: 8]);
	endtask

	task automatic queue_header(input int unsigned w, input int unsigned h);
		logic [31:0] data_size;
		data_size = 32'(row_stride(w) * h);
		queue_byte(MAGIC_B);
		queue_byte(MAGIC_M);
		queue_le(HEADER_LEN + data_size, 4);
		// two reserved halfwords
		queue_le(32'd0, 4);
		queue_le(HEADER_LEN, 4);
		queue_le(INFO_LEN, 4);
		queue_le(32'(w), 4);
		queue_le(32'(h), 4);
		queue_le(32'd1, 2);
		queue_le(32'd24, 2);
		queue_le(32'd0, 4);
		queue_le(data_size, 4);
		queue_le(PELS_PER_METER, 4);
		queue_le(PELS_PER_METER, 4);
		queue_le(32'd0, 4);
		queue_le(32'd0, 4);
	endtask

	// Expected bytes of one pixel: optional header, B G R, row padding
	task automatic predict_pixel_bytes(input logic [15:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned pad;
		bit          file_end;
		w        = clamp_dim(width_reg, MAX_W);
		h        = clamp_dim(height_reg, MAX_H);
		file_end = 1'b0;
		if (!header_sent) begin
			queue_header(w, h);
			header_sent = 1'b1;
		end
		queue_byte(scale_chan(32'(px[4:0]), 31));
		queue_byte(scale_chan(32'(px[10:5]), 63));
		queue_byte(scale_chan(32'(px[15:11]), 31));
		if (col_pos + 1 >= w) begin
			pad = row_stride(w) - 3 * w;
			repeat (pad) queue_byte(8'h00);
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos     = 0;
				header_sent = 1'b0;
				file_end    = 1'b1;
				file_cnt++;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		expected_file_bytes[expected_file_bytes.size()-1].last = 1'b1;
		expected_file_bytes[expected_file_bytes.size()-1].eoi  = file_end;
	endtask

	// Follow the channels at each edge; counts leave through nonblocking updates
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg   = 11'd320;
			height_reg  = 11'd240;
			col_pos     = 0;
			row_pos     = 0;
			header_sent = 1'b0;
			err_cnt     = 0;
			byte_cnt    = 0;
			file_cnt    = 0;
			expected_file_bytes.delete();
			mismatches  <= 0;
			outstanding <= 0;
			bytes_seen  <= 0;
			files_done  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_IMAGE_HEIGHT)
					height_reg = cfg_data;
			end
			if (in_valid && in_ready)
				predict_pixel_bytes(pixel_rgb565);
			if (out_valid && out_ready) begin
				got_byte = '{data: data_byte, last: last_of_run, eoi: end_of_image};
				if (expected_file_bytes.size() == 0) begin
					if (err_cnt < 10)
						$display("byte %0d: unexpected output, data %02h last %0b end %0b",
							byte_cnt, data_byte, last_of_run, end_of_image);
					err_cnt++;
				end else begin
					want_byte = expected_file_bytes.pop_front();
					if (got_byte !== want_byte) begin
						if (err_cnt < 10)
							$display("byte %0d: expected data %02h last %0b end %0b, got data %02h last %0b end %0b",
								byte_cnt, want_byte.data, want_byte.last, want_byte.eoi,
								got_byte.data, got_byte.last, got_byte.eoi);
						err_cnt++;
					end
				end
				byte_cnt++;
			end
			mismatches  <= err_cnt;
			outstanding <= expected_file_bytes.size();
			bytes_seen  <= byte_cnt;
			files_done  <= file_cnt;
		end
	end

endmodule

[bench/rgb565_to_bmp24_stream_writer_tb.sv]
`timescale 1ns / 1ps
// Top of the BMP writer testbench: clock, reset, register writes, pixel and ready stimulus.
// Depends on rgb565_to_bmp24_stream_writer, bmp_stream_checker and rgbbmp_pkg.
module rgb565_to_bmp24_stream_writer_tb;
	import rgbbmp_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_PER_MODE = 90;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 16;

	// Sender idle and receiver stall percentages per phase
	localparam int SENDER_IDLE[4] = '{0, 71, 0, 18};
	localparam int RECV_STALL[4]  = '{0, 0, 71, 18};

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [DIM_W-1:0]     cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [15:0]          pixel_rgb565 = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [7:0]           data_byte;
	logic                 last_of_run;
	logic                 end_of_image;

	int mismatches;
	int outstanding;
	int bytes_seen;
	int files_done;

	int idle_pct     = 0;
	int stall_pct    = 0;
	int pixels_sent  = 0;
	int settings_cnt = 0;
	int cycle_count  = 0;
	bit hold_req     = 1'b0;
	bit hold_ack     = 1'b0;
	int hold_left    = 0;

	logic [15:0] opening_pixels[8] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
		16'h001F, 16'h0821, 16'h7BEF, 16'h8410};

	rgb565_to_bmp24_stream_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_rgb565 (pixel_rgb565),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.last_of_run  (last_of_run),
		.end_of_image (end_of_image)
	);

	bmp_stream_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_rgb565 (pixel_rgb565),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.last_of_run  (last_of_run),
		.end_of_image (end_of_image),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.bytes_seen   (bytes_seen),
		.files_done   (files_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Long output hold-off, started by a toggle of hold_req
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Byte receiver: random stalls, and held stalled throughout a hold-off
	always @(posedge clk) begin
		if (hold_left != 0)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycle_count, outstanding);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one pixel after random idle cycles; return once it is taken
	task automatic send_pixel(input logic [15:0] px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pixel_rgb565 <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixels_sent++;
	endtask

	// Drop valid and hold until every expected byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_valid <= 1'b0;
		settings_cnt++;
	endtask

	initial begin
		int n;
		int seg;
		int sent_in_mode;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size, channel extremes and single-channel pixels
		foreach (opening_pixels[i])
			send_pixel(opening_pixels[i]);

		// Shrink to 1x1 mid-image: every pixel closes a file
		wait_drained();
		set_image_size(11'd1, 11'd1);
		send_pixel(16'hAAAA);
		send_pixel(16'h5555);

		// Zero registers read as one
		wait_drained();
		set_image_size(11'd0, 11'd0);
		send_pixel(16'h1234);
		send_pixel(16'hEDCB);

		// All-ones registers saturate to the maximum
		wait_drained();
		set_image_size(11'd2047, 11'd2047);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);

		// Column already at the last column of the new width; three pad bytes per row
		wait_drained();
		set_image_size(11'd3, 11'd2);
		for (int i = 0; i < 4; i++)
			send_pixel(16'($urandom));

		// Just above and exactly at the maximum
		wait_drained();
		set_image_size(11'd1025, 11'd1024);
		send_pixel(16'h0001);

		// Row of four pixels needs no padding
		wait_drained();
		set_image_size(11'd4, 11'd1);
		for (int i = 0; i < 5; i++)
			send_pixel(16'($urandom));

		// Random phases under each idling pattern
		for (int m = 0; m < 4; m++) begin
			idle_pct     = SENDER_IDLE[m];
			stall_pct    = RECV_STALL[m];
			sent_in_mode = 0;
			seg          = 0;
			while (sent_in_mode < RANDOM_PER_MODE) begin
				wait_drained();
				// mostly small images so files close often
				if ($urandom_range(99) < 80) begin
					w = 11'($urandom_range(1, 9));
					h = 11'($urandom_range(1, 4));
				end else begin
					w = 11'($urandom_range(0, 2047));
					h = 11'($urandom_range(0, 2047));
				end
				set_image_size(w, h);
				n = (m == 0 && seg == 0) ? 30 : $urandom_range(8, 30);
				for (int i = 0; i < n; i++) begin
					// fill the block behind a stalled output, later pause the input
					if (m == 0 && seg == 0 && i == 4)
						hold_req <= ~hold_req;
					if (m == 0 && seg == 0 && i == 20)
						wait_drained();
					send_pixel(16'($urandom));
				end
				sent_in_mode += n;
				seg++;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d pixels across %0d size settings and four idle patterns.",
			pixels_sent, settings_cnt);
		$display("Checked %0d output bytes, %0d complete files.", bytes_seen, files_done);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
